>>> hdl/rclfr_pkg.sv
// ---------------------------------------------------------------------------
// rclfr_pkg
// Shared types and constants for the RC link frame receiver.
// ---------------------------------------------------------------------------
package rclfr_pkg;

    // frame format
    localparam int CHANNEL_COUNT   = 16;
    localparam int MAX_FRAME_BYTES = 64;
    localparam int PAYLOAD_BYTES   = 22;
    localparam int CHANNEL_BITS    = 11;

    localparam logic [7:0] CRC_POLY  = 8'hD5;
    localparam logic [7:0] RC_TYPE   = 8'h16;
    localparam logic [7:0] RC_LENGTH = 8'd24;
    localparam logic [7:0] LEN_MIN   = 8'd2;
    localparam logic [7:0] LEN_MAX   = 8'd62;

    localparam logic [7:0] SYNC_ZERO = 8'h00;
    localparam logic [7:0] SYNC_C8   = 8'hC8;
    localparam logic [7:0] SYNC_EA   = 8'hEA;
    localparam logic [7:0] SYNC_EC   = 8'hEC;
    localparam logic [7:0] SYNC_EE   = 8'hEE;

    // derived widths
    localparam int ADDR_W = $clog2(PAYLOAD_BYTES);
    localparam int ACC_W  = CHANNEL_BITS + 7;
    localparam int NBIT_W = $clog2(ACC_W + 1);

    // parser sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CRC,
        ST_EMIT
    } t_state;

    // command to the serial crc unit
    typedef struct packed {
        logic       start;
        logic       init;
        logic [7:0] data;
    } t_crc_cmd;

    // payload store write port
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_store_wr;

    // true for any of the accepted sync bytes
    function automatic logic is_sync(input logic [7:0] b);
        return (b == SYNC_ZERO) || (b == SYNC_C8) || (b == SYNC_EA) ||
               (b == SYNC_EC) || (b == SYNC_EE);
    endfunction

endpackage

>>> hdl/rclfr_if.sv
// ---------------------------------------------------------------------------
// rclfr_if
// Valid/ready channels for received bytes and unpacked channel results.
// ---------------------------------------------------------------------------
interface rclfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       byte_present;
    logic       line_error;

    modport source (output valid, output rx_byte, output byte_present,
                    output line_error, input ready);
    modport sink   (input valid, input rx_byte, input byte_present,
                    input line_error, output ready);
endinterface

interface rclfr_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic        last_channel;

    modport source (output valid, output channel_index, output channel_value,
                    output last_channel, input ready);
    modport sink   (input valid, input channel_index, input channel_value,
                    input last_channel, output ready);
endinterface

>>> hdl/rc_link_frame_receiver.sv
// ---------------------------------------------------------------------------
// rc_link_frame_receiver
// Byte-serial link frame parser: sync hunt, length check, CRC-8 check and
// unpacking of sixteen 11-bit RC channels from valid channel frames.
// ---------------------------------------------------------------------------
//  channel | dir | handshake      | payload
//  i_in    | in  | valid / ready  | rx_byte, byte_present, line_error
//  o_out   | out | valid / ready  | channel_index, channel_value, last_channel
//
//  a type or payload byte: accept, 8 steps of the serial crc, back to idle
//  sync and length bytes and empty transactions leave i_in ready; a crc byte
//  does too unless it starts the unpacker
//  a channel frame with a good crc is then unpacked (22 store reads, 16
//  results, back to idle); the unpacker waits while o_out is held off
//  i_rst_n synchronous active low; the payload store needs no clearing
//  i_in.ready is low while the crc unit or the unpacker is busy
module rc_link_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rclfr_in_if.sink    i_in,
    rclfr_out_if.source o_out
);
    import rclfr_pkg::*;

    t_state    r_state, n_state;
    logic [6:0] r_pos, n_pos;
    logic [6:0] r_exp, n_exp;
    logic [7:0] r_type, n_type;

    t_crc_cmd  crc_cmd;
    t_store_wr store_wr;
    logic      unp_start;
    logic      crc_busy;
    logic      unp_busy;
    logic [7:0] crc_val;
    logic      accept;
    logic      in_ready;

    logic [7:0] b;
    logic [8:0] total;
    logic [6:0] pos_inc;
    logic [6:0] pay_idx;

    assign accept = i_in.valid && in_ready;
    assign b      = i_in.rx_byte;
    assign total  = {1'b0, b} + 9'd2;
    assign pos_inc = r_pos + 7'd1;
    assign pay_idx = r_pos - 7'd3;

    // parser decode of one transaction
    always_comb begin
        n_pos     = r_pos;
        n_exp     = r_exp;
        n_type    = r_type;
        crc_cmd   = '0;
        store_wr  = '0;
        unp_start = 1'b0;
        if (accept && i_in.byte_present) begin
            if (r_pos == 7'd0) begin
                if (is_sync(b)) begin
                    n_pos = 7'd1;
                end
            end else if (r_pos == 7'd1) begin
                if (b < LEN_MIN || b > LEN_MAX) begin
                    n_pos = is_sync(b) ? 7'd1 : 7'd0;
                    n_exp = '0;
                end else begin
                    n_exp = total[6:0];
                    n_pos = 7'd2;
                    if (total > 9'(MAX_FRAME_BYTES)) begin
                        n_pos = '0;
                        n_exp = '0;
                    end
                end
            end else if ({1'b0, r_pos} + 8'd1 == {1'b0, r_exp}) begin
                // crc byte: judge the frame
                unp_start = (b == crc_val) && (r_type == RC_TYPE) &&
                            ({1'b0, r_exp} == RC_LENGTH + 8'd2);
                n_pos = '0;
                n_exp = '0;
            end else begin
                crc_cmd.start = 1'b1;
                crc_cmd.data  = b;
                if (r_pos == 7'd2) begin
                    n_type       = b;
                    crc_cmd.init = 1'b1;
                end else if (pay_idx < 7'(PAYLOAD_BYTES)) begin
                    store_wr.we   = 1'b1;
                    store_wr.addr = pay_idx[ADDR_W-1:0];
                    store_wr.data = b;
                end
                n_pos = pos_inc;
                if (pos_inc >= 7'(MAX_FRAME_BYTES) || pos_inc == 7'd0) begin
                    n_pos = '0;
                    n_exp = '0;
                end
            end
        end
        // line error resets the parser after the byte
        if (accept && i_in.line_error) begin
            n_pos = '0;
            n_exp = '0;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (unp_start) begin
                    n_state = ST_EMIT;
                end else if (crc_cmd.start) begin
                    n_state = ST_CRC;
                end
            end
            ST_CRC: begin
                if (!crc_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!unp_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        case (r_state)
            ST_IDLE: in_ready = 1'b1;
            default: in_ready = 1'b0;
        endcase
    end

    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_exp   <= '0;
            r_type  <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_exp   <= n_exp;
            r_type  <= n_type;
        end
    end

    // serial crc unit
    rclfr_crc8 u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (crc_cmd),
        .o_busy  (crc_busy),
        .o_crc   (crc_val)
    );

    // payload store and channel unpacker
    rclfr_unpack u_unpack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (store_wr),
        .i_start (unp_start),
        .o_busy  (unp_busy),
        .o_out   (o_out)
    );

    // no new byte while the crc unit or the unpacker is still working
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (!crc_busy && !unp_busy))
        else $error("input ready while busy");

    // the crc unit runs exactly eight steps per byte
    a_crc_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(crc_busy) |-> ##8 !crc_busy)
        else $error("crc step count wrong");

    // the payload store is never written while it is being unpacked
    a_store_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_wr.we |-> !unp_busy)
        else $error("payload write during unpack");

    // the final channel carries the last index
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last_channel) |->
            (o_out.channel_index == 4'(CHANNEL_COUNT - 1)))
        else $error("last flag on wrong channel");

endmodule

>>> hdl/rclfr_crc8.sv
// ---------------------------------------------------------------------------
// rclfr_crc8
// Bit-serial CRC-8 (poly 0xD5), one shift step per cycle, holds running crc.
// ---------------------------------------------------------------------------
module rclfr_crc8 (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rclfr_pkg::t_crc_cmd i_cmd,
    output logic                o_busy,
    output logic [7:0]          o_crc
);
    import rclfr_pkg::*;

    logic       r_busy, n_busy;
    logic [2:0] r_cnt, n_cnt;
    logic [7:0] r_crc, n_crc;

    // load byte, then eight shift steps
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_crc  = r_crc;
        if (i_cmd.start) begin
            n_crc  = (i_cmd.init ? 8'h00 : r_crc) ^ i_cmd.data;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_crc = r_crc[7] ? ({r_crc[6:0], 1'b0} ^ CRC_POLY) : {r_crc[6:0], 1'b0};
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_crc  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_crc  <= n_crc;
        end
    end

    assign o_busy = r_busy;
    assign o_crc  = r_crc;

endmodule

>>> hdl/rclfr_unpack.sv
// ---------------------------------------------------------------------------
// rclfr_unpack
// Payload store and little-endian 11-bit channel unpacker with output register.
// ---------------------------------------------------------------------------
module rclfr_unpack (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rclfr_pkg::t_store_wr i_wr,
    input  logic                 i_start,
    output logic                 o_busy,
    rclfr_out_if.source          o_out
);
    import rclfr_pkg::*;

    logic [7:0]        r_mem [PAYLOAD_BYTES];
    logic [7:0]        r_rd_data;
    logic              r_rd_pend, n_rd_pend;
    logic [ADDR_W-1:0] r_rd_addr, n_rd_addr;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [NBIT_W-1:0] r_nbits, n_nbits;
    logic [3:0]        r_ch, n_ch;
    logic              r_busy, n_busy;
    logic              r_valid, n_valid;
    logic [3:0]        r_index, n_index;
    logic [10:0]       r_value, n_value;
    logic              r_last, n_last;
    logic              rd_en;
    logic              emit;

    // payload memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
    end

    // fetch a byte while under 11 bits are held and no read is pending
    assign rd_en = r_busy && !r_rd_pend && (r_nbits < NBIT_W'(CHANNEL_BITS)) &&
                   (r_rd_addr < ADDR_W'(PAYLOAD_BYTES));
    assign emit  = r_busy && !r_rd_pend && (r_nbits >= NBIT_W'(CHANNEL_BITS)) &&
                   (!r_valid || o_out.ready);

    // bit buffer and output register
    always_comb begin
        n_rd_pend = rd_en;
        n_rd_addr = rd_en ? r_rd_addr + ADDR_W'(1) : r_rd_addr;
        n_acc     = r_acc;
        n_nbits   = r_nbits;
        n_ch      = r_ch;
        n_busy    = r_busy;
        n_valid   = r_valid && !o_out.ready;
        n_index   = r_index;
        n_value   = r_value;
        n_last    = r_last;
        if (i_start) begin
            n_rd_pend = 1'b0;
            n_rd_addr = '0;
            n_acc     = '0;
            n_nbits   = '0;
            n_ch      = '0;
            n_busy    = 1'b1;
        end else if (r_rd_pend) begin
            n_acc   = r_acc | (ACC_W'(r_rd_data) << r_nbits);
            n_nbits = r_nbits + NBIT_W'(8);
        end else if (emit) begin
            n_valid = 1'b1;
            n_index = r_ch;
            n_value = r_acc[CHANNEL_BITS-1:0];
            n_last  = (r_ch == 4'(CHANNEL_COUNT - 1));
            n_acc   = r_acc >> CHANNEL_BITS;
            n_nbits = r_nbits - NBIT_W'(CHANNEL_BITS);
            n_ch    = r_ch + 4'd1;
            if (r_ch == 4'(CHANNEL_COUNT - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
            r_rd_addr <= '0;
            r_nbits   <= '0;
            r_ch      <= '0;
            r_busy    <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_rd_pend <= n_rd_pend;
            r_rd_addr <= n_rd_addr;
            r_nbits   <= n_nbits;
            r_ch      <= n_ch;
            r_busy    <= n_busy;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_index <= n_index;
        r_value <= n_value;
        r_last  <= n_last;
    end

    assign o_busy              = r_busy;
    assign o_out.valid         = r_valid;
    assign o_out.channel_index = r_index;
    assign o_out.channel_value = r_value;
    assign o_out.last_channel  = r_last;

endmodule

>>> dv/tb_rc_link_frame_receiver.sv
// ---------------------------------------------------------------------------
// tb_rc_link_frame_receiver
// Drives link bytes into the frame receiver and checks every unpacked RC
// channel it returns. A table of directed frames and single bytes comes
// first, then random traffic made mostly of well-formed channel frames with
// random payloads, mixed with broken frames, line errors and noise. Expected
// channels come from a bit-true parser model kept in this file, or from typed values in some directed rows.
// ---------------------------------------------------------------------------
module tb_rc_link_frame_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    import rclfr_pkg::*;

    // one transaction on the byte channel
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       present;
        logic       lerr;
    } t_link_item;

    // one transaction on the channel output
    typedef struct packed {
        logic [3:0]  idx;
        logic [10:0] value;
        logic        last;
    } t_chan;

    typedef enum {ROW_BYTE, ROW_FRAME} t_row_kind;

    // directed row: a single byte or a whole frame
    // typed_n < 0 means the channels come from the parser model
    typedef struct {
        t_row_kind   kind;
        logic [7:0]  lead;
        logic        present;
        logic        lerr;
        logic [7:0]  len;
        logic [7:0]  ftype;
        int          fill;
        bit          crc_bad;
        int          err_at;
        int          typed_n;
        logic [10:0] typed_val;
    } t_stim_row;

    localparam int N_ROWS  = 14;
    localparam int CRC_POS = int'(RC_LENGTH) + 1;

    t_stim_row stim_rows [N_ROWS] = '{
        // absent byte, then a non-sync byte while hunting
        '{ROW_BYTE,  8'h55,     1'b0, 1'b0, 8'd0,      8'h00,   0,   1'b0, -1,  0, 11'd0},
        '{ROW_BYTE,  8'hFF,     1'b1, 1'b0, 8'd0,      8'h00,   0,   1'b0, -1,  0, 11'd0},
        // all-zero payload
        '{ROW_FRAME, SYNC_C8,   1'b1, 1'b0, RC_LENGTH, RC_TYPE, 0,   1'b0, -1, 16, 11'd0},
        // bad crc, and shortest frame
        '{ROW_FRAME, SYNC_EC,   1'b1, 1'b0, RC_LENGTH, RC_TYPE, 'h5A, 1'b1, -1, 0, 11'd0},
        '{ROW_FRAME, SYNC_C8,   1'b1, 1'b0, LEN_MIN,   RC_TYPE, 0,   1'b0, -1,  0, 11'd0},
        // bad length bytes that are not sync restart the hunt
        '{ROW_BYTE,  SYNC_C8,   1'b1, 1'b0, 8'd0,      8'h00,   0,   1'b0, -1, -1, 11'd0},
        '{ROW_BYTE,  8'h3F,     1'b1, 1'b0, 8'd0,      8'h00,   0,   1'b0, -1, -1, 11'd0},
        '{ROW_BYTE,  SYNC_C8,   1'b1, 1'b0, 8'd0,      8'h00,   0,   1'b0, -1, -1, 11'd0},
        '{ROW_BYTE,  8'h01,     1'b1, 1'b0, 8'd0,      8'h00,   0,   1'b0, -1, -1, 11'd0},
        // line error with no byte
        '{ROW_BYTE,  8'h00,     1'b0, 1'b1, 8'd0,      8'h00,   0,   1'b0, -1,  0, 11'd0},
        // sync bytes in the length slot resync the hunt
        '{ROW_BYTE,  SYNC_C8,   1'b1, 1'b0, 8'd0,      8'h00,   0,   1'b0, -1, -1, 11'd0},
        '{ROW_BYTE,  SYNC_EE,   1'b1, 1'b0, 8'd0,      8'h00,   0,   1'b0, -1, -1, 11'd0},
        // line error on the crc byte still emits the all-one frame
        '{ROW_FRAME, SYNC_EE,   1'b1, 1'b0, RC_LENGTH, RC_TYPE, 255, 1'b0, CRC_POS, 16,
          11'h7FF},
        '{ROW_BYTE,  8'hA5,     1'b1, 1'b1, 8'd0,      8'h00,   0,   1'b0, -1,  0, 11'd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    rclfr_in_if  link_in();
    rclfr_out_if chan_out();

    rc_link_frame_receiver u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (link_in),
        .o_out   (chan_out)
    );

    // parser model state
    logic [6:0] hunt_pos;
    logic [6:0] frame_total;
    logic [7:0] crc_acc;
    logic [7:0] held_type;
    logic [7:0] held_payload [PAYLOAD_BYTES];

    t_chan      decoded_channels [$];
    t_chan      awaited_channels [$];
    t_link_item link_items [$];

    int fault_count       = 0;
    bit src_steady        = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------

    function automatic bit sync_byte(input logic [7:0] b);
        return (b == SYNC_ZERO) || (b == SYNC_C8) || (b == SYNC_EA) ||
               (b == SYNC_EC) || (b == SYNC_EE);
    endfunction

    // crc-8, poly 0xd5, msb first
    function automatic logic [7:0] crc8_d5(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // advance the model by one transaction, channels go to decoded_channels
    task automatic parse_link_item(input t_link_item it);
        logic [7:0]   b;
        logic [175:0] flat;
        int           nxt;
        int           j;
        b = it.rx_byte;
        if (it.present) begin
            if (hunt_pos == 7'd0) begin
                if (sync_byte(b)) hunt_pos = 7'd1;
            end else if (hunt_pos == 7'd1) begin
                if (b < LEN_MIN || b > LEN_MAX) begin
                    hunt_pos    = sync_byte(b) ? 7'd1 : 7'd0;
                    frame_total = 7'd0;
                end else begin
                    frame_total = 7'(b + 8'd2);
                    hunt_pos    = 7'd2;
                    if (int'(frame_total) > MAX_FRAME_BYTES) begin
                        hunt_pos    = 7'd0;
                        frame_total = 7'd0;
                    end
                end
            end else if (int'(hunt_pos) + 1 == int'(frame_total)) begin
                // crc byte: judge the frame
                if (b == crc_acc && held_type == RC_TYPE &&
                    frame_total == 7'(RC_LENGTH + 8'd2)) begin
                    for (int k = 0; k < PAYLOAD_BYTES; k++) flat[8*k +: 8] = held_payload[k];
                    for (int i = 0; i < CHANNEL_COUNT; i++) begin
                        decoded_channels.push_back('{idx: 4'(i), value: flat[11*i +: 11],
                                                    last: (i == CHANNEL_COUNT - 1)});
                    end
                end
                hunt_pos    = 7'd0;
                frame_total = 7'd0;
            end else begin
                if (hunt_pos == 7'd2) begin
                    held_type = b;
                    crc_acc   = crc8_d5(8'h00, b);
                end else begin
                    j = int'(hunt_pos) - 3;
                    if (j < PAYLOAD_BYTES) held_payload[j] = b;
                    crc_acc = crc8_d5(crc_acc, b);
                end
                nxt      = (int'(hunt_pos) + 1) & 'h7F;
                hunt_pos = 7'(nxt);
                if (nxt >= MAX_FRAME_BYTES || nxt == 0) begin
                    hunt_pos    = 7'd0;
                    frame_total = 7'd0;
                end
            end
        end
        // line error resets after the byte
        if (it.lerr) begin
            hunt_pos    = 7'd0;
            frame_total = 7'd0;
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // build a frame; fill < 0 gives random payload, err_at marks a line error
    task automatic queue_frame(input logic [7:0] sync, input logic [7:0] len,
                               input logic [7:0] ftype, input int fill,
                               input bit crc_bad, input int err_at);
        logic [7:0] body [$];
        logic [7:0] crc;
        logic [7:0] pb;
        int         n_pay;
        body  = {sync, len, ftype};
        n_pay = int'(len) - 2;
        crc   = crc8_d5(8'h00, ftype);
        for (int k = 0; k < n_pay; k++) begin
            if (fill >= 0) pb = 8'(fill);
            else if ($urandom_range(0, 3) == 0) pb = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else pb = 8'($urandom);
            body.push_back(pb);
            crc = crc8_d5(crc, pb);
        end
        if (crc_bad) crc = crc ^ (8'h01 << $urandom_range(0, 7));
        body.push_back(crc);
        foreach (body[k]) begin
            link_items.push_back('{rx_byte: body[k], present: 1'b1, lerr: (k == err_at)});
        end
    endtask

    // random traffic, mostly good channel frames
    task automatic queue_random_burst();
        int         r;
        int         n;
        logic [7:0] sync;
        t_link_item it;
        r = $urandom_range(0, 19);
        case ($urandom_range(0, 4))
            0: sync = SYNC_ZERO;
            1: sync = SYNC_C8;
            2: sync = SYNC_EA;
            3: sync = SYNC_EC;
            default: sync = SYNC_EE;
        endcase
        if (r < 11) begin
            queue_frame(sync, RC_LENGTH, RC_TYPE, -1, 1'b0,
                        ($urandom_range(0, 9) == 0) ? CRC_POS : -1);
        end else if (r < 13) begin
            queue_frame(sync, 8'($urandom_range(2, 62)),
                        $urandom_range(0, 1) ? RC_TYPE : 8'($urandom), -1, 1'b0, -1);
        end else if (r < 15) begin
            queue_frame(sync, RC_LENGTH, RC_TYPE, -1, 1'b1, -1);
        end else if (r < 17) begin
            queue_frame(sync, RC_LENGTH, RC_TYPE, -1, 1'b0, $urandom_range(0, CRC_POS));
        end else begin
            // noise, sometimes followed by a line error to clean up
            n = $urandom_range(1, 6);
            repeat (n) begin
                it.rx_byte = 8'($urandom);
                it.present = ($urandom_range(0, 3) != 0);
                it.lerr    = ($urandom_range(0, 7) == 0);
                link_items.push_back(it);
            end
            if ($urandom_range(0, 1) == 1) begin
                it = '{rx_byte: 8'h00, present: 1'b0, lerr: 1'b1};
                link_items.push_back(it);
            end
        end
    endtask

    // sender gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (src_steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // predict, then present one transaction and wait for it to be taken
    task automatic send_item(input t_link_item it, input bit use_model);
        int gap;
        gap = pick_gap();
        parse_link_item(it);
        if (use_model) begin
            foreach (decoded_channels[k]) awaited_channels.push_back(decoded_channels[k]);
        end
        decoded_channels.delete();
        if (gap > 0) begin
            link_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        link_in.valid        <= 1'b1;
        link_in.rx_byte      <= it.rx_byte;
        link_in.byte_present <= it.present;
        link_in.line_error   <= it.lerr;
        @(posedge clk);
        while (!link_in.ready) @(posedge clk);
    endtask

    // hold the sender until every awaited channel is out
    task automatic wait_for_channels();
        if (awaited_channels.size() != 0) begin
            link_in.valid <= 1'b0;
            while (awaited_channels.size() != 0) @(posedge clk);
        end
    endtask

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) $display("%s", msg);
    endtask

    // ------------------------------------------------------------------
    // output side: random stalls with stretches of steady ready
    // ------------------------------------------------------------------
    initial begin
        int hold;
        int phase;
        int r;
        hold           = 0;
        phase          = 0;
        chan_out.ready = 1'b0;
        forever begin
            @(posedge clk);
            phase++;
            if (phase % 400 < 60) begin
                chan_out.ready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
                chan_out.ready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    chan_out.ready <= 1'b1;
                end else if (r < 94) begin
                    chan_out.ready <= 1'b0;
                    hold = $urandom_range(0, 2);
                end else begin
                    chan_out.ready <= 1'b0;
                    hold = $urandom_range(8, 40);
                end
            end
        end
    end

    // channel checker
    always @(posedge clk) begin : check_channels
        t_chan want;
        if (rst_n && chan_out.valid && chan_out.ready) begin
            if (awaited_channels.size() == 0) begin
                note_fault($sformatf("unexpected channel: idx %0d value %0d last %0b",
                                     chan_out.channel_index, chan_out.channel_value,
                                     chan_out.last_channel));
            end else begin
                want = awaited_channels.pop_front();
                if (chan_out.channel_index !== want.idx ||
                    chan_out.channel_value !== want.value ||
                    chan_out.last_channel !== want.last) begin
                    note_fault($sformatf({"channel mismatch: expected idx %0d value %0d ",
                                          "last %0b, got idx %0d value %0d last %0b"},
                                         want.idx, want.value, want.last,
                                         chan_out.channel_index, chan_out.channel_value,
                                         chan_out.last_channel));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        t_stim_row  row;
        t_link_item it;
        int         rand_bytes;
        rst_n                = 1'b0;
        link_in.valid        = 1'b0;
        link_in.rx_byte      = 8'h00;
        link_in.byte_present = 1'b0;
        link_in.line_error   = 1'b0;
        hunt_pos             = 7'd0;
        frame_total          = 7'd0;
        crc_acc              = 8'h00;
        held_type            = 8'h00;
        rand_bytes           = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < N_ROWS; r++) begin
            row = stim_rows[r];
            link_items.delete();
            if (row.kind == ROW_BYTE) begin
                it = '{rx_byte: row.lead, present: row.present, lerr: row.lerr};
                link_items.push_back(it);
            end else begin
                queue_frame(row.lead, row.len, row.ftype, row.fill, row.crc_bad, row.err_at);
            end
            while (link_items.size() > 0) begin
                it = link_items.pop_front();
                // typed channels are all due on the row's final byte
                if (link_items.size() == 0) begin
                    for (int i = 0; i < row.typed_n; i++) begin
                        awaited_channels.push_back('{idx: 4'(i), value: row.typed_val,
                                                    last: (i == CHANNEL_COUNT - 1)});
                    end
                end
                send_item(it, row.typed_n < 0);
            end
            if (r == 2 || r == 12) wait_for_channels();
        end

        // random traffic
        while (rand_bytes < 60) begin
            src_steady = ($urandom_range(0, 5) == 0);
            queue_random_burst();
            while (link_items.size() > 0) begin
                // stray empty transaction inside the burst
                if ($urandom_range(0, 15) == 0) begin
                    it = '{rx_byte: 8'($urandom), present: 1'b0, lerr: 1'b0};
                    send_item(it, 1'b1);
                end
                it = link_items.pop_front();
                if (it.present) rand_bytes++;
                send_item(it, 1'b1);
            end
            if ($urandom_range(0, 7) == 0) wait_for_channels();
        end

        // drain and look for stray channels
        link_in.valid <= 1'b0;
        while (awaited_channels.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fault_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
